>>> rtl/level_interrupt_controller_32_assert.svh
// ----------------------------------------------------------------------------
// level_interrupt_controller_32_assert.svh
// Assertion macros used by the interrupt controller RTL
// ----------------------------------------------------------------------------
`ifndef LEVEL_INTERRUPT_CONTROLLER_32_ASSERT_SVH
`define LEVEL_INTERRUPT_CONTROLLER_32_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interrupt controller check failed");

// next-cycle implication, sampled on clk, off during reset
`define LIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interrupt controller check failed");

`endif

>>> rtl/lic_pkg.sv
// ----------------------------------------------------------------------------
// lic_pkg
// Types and constants of the level interrupt controller
// ----------------------------------------------------------------------------
package lic_pkg;

    // item kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register byte offsets
    localparam logic [7:0] OFF_REV      = 8'h00;
    localparam logic [7:0] OFF_ACK      = 8'h20;
    localparam logic [7:0] OFF_STATUS   = 8'h24;
    localparam logic [7:0] OFF_POLARITY = 8'h28;
    localparam logic [7:0] OFF_ACKMODE  = 8'h2C;
    localparam logic [7:0] OFF_MASK     = 8'h48;

    // lowest revision that allows ack mode
    localparam logic [7:0] MIN_ACK_REV  = 8'd70;
    localparam logic [7:0] REV_RESET    = 8'd70;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        reg_offset;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] line_levels;
    } lic_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_out;
    } lic_result_t;

    typedef struct packed {
        logic irq_now;
        logic ack_mode;
    } lic_status_t;

endpackage

>>> rtl/lic_core.sv
// ----------------------------------------------------------------------------
// lic_core
// Interrupt state registers and the single-pass update for one item
// ----------------------------------------------------------------------------
module lic_core #(
    parameter int unsigned NUM_LINES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  lic_pkg::lic_item_t item,
    input  logic [7:0]         revision,
    output lic_pkg::lic_result_t result,
    output lic_pkg::lic_status_t status
);
    import lic_pkg::*;

    logic [NUM_LINES-1:0] pending_reg, pending_next;
    logic [NUM_LINES-1:0] mask_reg, mask_next;
    logic [NUM_LINES-1:0] polarity_reg, polarity_next;
    logic                 ack_mode_reg, ack_mode_next;
    logic [NUM_LINES-1:0] active;
    logic [WORD_W-1:0]    rd;

    // lines that differ from their polarity are active
    assign active = item.line_levels[NUM_LINES-1:0] ^ polarity_reg;

    // next state for the item
    always_comb
    begin
        pending_next  = pending_reg;
        mask_next     = mask_reg;
        polarity_next = polarity_reg;
        ack_mode_next = ack_mode_reg;
        case (item.op)
            OP_TICK:
            begin
                pending_next = ack_mode_reg ? (pending_reg | active) : active;
            end
            OP_WRITE:
            begin
                case (item.reg_offset)
                    OFF_ACK:
                    begin
                        if (ack_mode_reg)
                        begin
                            pending_next = pending_reg & ~item.write_data[NUM_LINES-1:0];
                        end
                    end
                    OFF_POLARITY: polarity_next = item.write_data[NUM_LINES-1:0];
                    OFF_ACKMODE:
                    begin
                        ack_mode_next = (revision >= MIN_ACK_REV) ? item.write_data[0] : 1'b0;
                    end
                    OFF_MASK:     mask_next = item.write_data[NUM_LINES-1:0];
                    default:      ;
                endcase
            end
            default: ;
        endcase
    end

    // read mux, reads have no side effects
    always_comb
    begin
        rd = '0;
        if (item.op == OP_READ)
        begin
            case (item.reg_offset)
                OFF_REV:      rd = WORD_W'(revision);
                OFF_STATUS:
                begin
                    rd = ack_mode_reg ? WORD_W'(pending_reg & mask_reg) : WORD_W'(pending_reg);
                end
                OFF_POLARITY: rd = WORD_W'(polarity_reg);
                OFF_ACKMODE:  rd = WORD_W'(ack_mode_reg);
                OFF_MASK:     rd = WORD_W'(mask_reg);
                default:      rd = '0;
            endcase
        end
    end

    // result of the item, irq taken after the update
    assign result.read_data = rd;
    assign result.irq_out   = |(pending_next & mask_next);

    assign status.irq_now  = |(pending_reg & mask_reg);
    assign status.ack_mode = ack_mode_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            mask_reg     <= '0;
            polarity_reg <= '0;
            ack_mode_reg <= 1'b0;
        end
        else if (step_en)
        begin
            pending_reg  <= pending_next;
            mask_reg     <= mask_next;
            polarity_reg <= polarity_next;
            ack_mode_reg <= ack_mode_next;
        end
    end

endmodule

>>> rtl/level_interrupt_controller_32.sv
// ----------------------------------------------------------------------------
// level_interrupt_controller_32
// Register block of a 32-line level interrupt controller
// ----------------------------------------------------------------------------
// Each input item is a line sample tick, a bus read or a bus write; each gives
// exactly one result item with the read data and the summary irq after the
// update. An item is taken into an input register, processed by the state
// update logic and written to a result register, so the block takes one item
// per cycle as long as the result side keeps taking items, and the result
// comes out of the result register after the input register. A stalled result
// holds the input register, and a new item is refused until the result is
// taken. The user must write the revision register through cfg_we / cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
module level_interrupt_controller_32 #(
    parameter int unsigned NUM_LINES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // revision register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // reg_offset[7:0], write_data[39:8], line_levels[71:40]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_data[31:0], irq_out[32], zero fill[39:33]
);
    import lic_pkg::*;

    logic [7:0]  revision_reg;
    logic        in_valid_reg;
    lic_item_t   in_item_reg;
    logic        res_valid_reg;
    lic_result_t res_reg;
    lic_result_t result;
    lic_status_t status;
    logic        result_free;
    logic        advance;

    // revision register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revision_reg <= REV_RESET;
        end
        else if (cfg_we)
        begin
            revision_reg <= cfg_wdata;
        end
    end

    // pipeline flow control
    assign result_free   = !res_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && result_free;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.op          <= s_axis_tuser;
            in_item_reg.reg_offset  <= s_axis_tdata[7:0];
            in_item_reg.write_data  <= s_axis_tdata[39:8];
            in_item_reg.line_levels <= s_axis_tdata[71:40];
        end
    end

    // state and update logic
    lic_core #(
        .NUM_LINES (NUM_LINES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .item     (in_item_reg),
        .revision (revision_reg),
        .result   (result),
        .status   (status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {7'b0, res_reg.irq_out, res_reg.read_data};

    // checks
    `include "level_interrupt_controller_32_assert.svh"

    `LIC_ASSERT_NEXT(a_ackmode_needs_rev, advance && in_item_reg.op == OP_WRITE && in_item_reg.reg_offset == OFF_ACKMODE && revision_reg < MIN_ACK_REV, !status.ack_mode)
    `LIC_ASSERT_NOW(a_irq_matches_state, res_valid_reg, res_reg.irq_out == status.irq_now)
    `LIC_ASSERT_NEXT(a_item_kept_on_stall, in_valid_reg && !result_free, in_valid_reg)
    `LIC_ASSERT_NEXT(a_advance_fills_result, advance, res_valid_reg)

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 32-line level interrupt controller
// ----------------------------------------------------------------------------
// Line ticks, register reads and register writes go in as stream items. A
// shadow copy of pending, mask, polarity, ack mode and revision predicts the
// read data and summary irq of every accepted item. Each result item is
// compared with the oldest prediction. A short table of directed accesses
// runs first. Random phases follow under several revision values and under
// different sender and receiver gap patterns.
// ----------------------------------------------------------------------------
module testbench;

    import lic_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 135;
    localparam logic [1:0]  OP_NONE     = 2'd3;
    localparam logic [7:0]  OFF_UNKNOWN = 8'hFF;
    localparam logic [31:0] ALL1        = 32'hFFFF_FFFF;
    localparam logic [31:0] LINE_MASK   = ALL1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  off;
        logic [31:0] data;
        logic [31:0] levels;
        logic        typed;
        logic [31:0] rd;
        logic        irq;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // reg_offset[7:0], write_data[39:8], line_levels[71:40]
    logic [1:0]  s_axis_tuser = '0;  // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // read_data[31:0], irq_out[32], zero fill[39:33]

    // shadow state of the controller
    logic [31:0] pend_word   = '0;
    logic [31:0] mask_word   = '0;
    logic [31:0] pol_word    = '0;
    logic        ack_mode_on = 1'b0;
    logic [7:0]  rev_value   = REV_RESET;

    lic_result_t awaited_replies [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic [7:0] known_offs [6] = '{OFF_REV, OFF_ACK, OFF_STATUS, OFF_POLARITY,
                                   OFF_ACKMODE, OFF_MASK};
    logic [7:0] phase_rev [PHASES] = '{8'd70, 8'd255, 8'd0, 8'd69, 8'd71, 8'd0,
                                       8'd70, 8'd255};

    // directed accesses, expected value typed in where it is obvious
    dir_row_t dir_table [26] = '{
        '{OP_READ,  OFF_REV,      32'h0,  32'h0, 1'b1, {24'd0, REV_RESET}, 1'b0},
        '{OP_READ,  OFF_STATUS,   32'h0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{OP_READ,  OFF_ACKMODE,  32'h0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{OP_READ,  OFF_UNKNOWN,  32'h0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{OP_NONE,  OFF_MASK,     ALL1,   ALL1,  1'b1, 32'h0, 1'b0},
        '{OP_WRITE, OFF_MASK,     ALL1,   32'h0, 1'b1, 32'h0, 1'b0},
        '{OP_TICK,  OFF_REV,      32'h0,  ALL1,  1'b1, 32'h0, 1'b1},
        '{OP_WRITE, OFF_ACK,      ALL1,   32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_POLARITY, ALL1,   32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  OFF_REV,      32'h0,  ALL1,  1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_POLARITY, 32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_ACKMODE,  32'hFFFF_FFFE, 32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_ACKMODE,  32'h1,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_ACKMODE,  32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  OFF_REV,      32'h0,  32'h1, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  OFF_REV,      32'h0,  ALL1,  1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_MASK,     32'h2,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_STATUS,   32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_ACK,      32'h2,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_REV,      32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_REV,      32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_STATUS,   ALL1,   32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, OFF_UNKNOWN,  ALL1,   32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_ACK,      32'h0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{OP_WRITE, OFF_ACKMODE,  32'h0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  OFF_STATUS,   32'h0,  32'h0, 1'b0, 32'h0, 1'b0}
    };

    level_interrupt_controller_32 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // update the shadow state with one access, return read data and irq after it
    function automatic lic_result_t predict_access(input lic_item_t acc);
        lic_result_t res;
        logic [31:0] active;
        res.read_data = '0;
        case (acc.op)
            OP_TICK:
            begin
                active = (acc.line_levels ^ pol_word) & LINE_MASK;
                pend_word = ack_mode_on ? (pend_word | active) : active;
            end
            OP_READ:
            begin
                case (acc.reg_offset)
                    OFF_REV:      res.read_data = {24'd0, rev_value};
                    OFF_STATUS:   res.read_data = ack_mode_on ? (pend_word & mask_word)
                                                              : pend_word;
                    OFF_POLARITY: res.read_data = pol_word;
                    OFF_ACKMODE:  res.read_data = {31'd0, ack_mode_on};
                    OFF_MASK:     res.read_data = mask_word;
                    default:      res.read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (acc.reg_offset)
                    OFF_ACK:
                    begin
                        if (ack_mode_on)
                        begin
                            pend_word = pend_word & ~acc.write_data;
                        end
                    end
                    OFF_POLARITY: pol_word = acc.write_data & LINE_MASK;
                    // below the minimum revision ack mode cannot be turned on
                    OFF_ACKMODE:  ack_mode_on = (rev_value >= MIN_ACK_REV) ?
                                                acc.write_data[0] : 1'b0;
                    OFF_MASK:     mask_word = acc.write_data & LINE_MASK;
                    default:      ;
                endcase
            end
            default: ;
        endcase
        res.irq_out = |(pend_word & mask_word);
        return res;
    endfunction

    task automatic log_mismatch(input string field, input logic [32:0] want,
                                input logic [32:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    // drive one item from a falling edge, hold it until accepted, predict it
    task automatic send_access(input lic_item_t acc, input logic typed,
                               input lic_result_t typed_res);
        lic_result_t want;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc.line_levels, acc.write_data, acc.reg_offset};
        s_axis_tuser  <= acc.op;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        want = predict_access(acc);
        awaited_replies.push_back(typed ? typed_res : want);
        @(negedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    // compare every result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lic_result_t got;
        lic_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.read_data = m_axis_tdata[31:0];
            got.irq_out   = m_axis_tdata[32];
            if (awaited_replies.size() == 0)
            begin
                log_mismatch("unexpected item", '0, got);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got.read_data !== want.read_data)
                begin
                    log_mismatch("read_data", {1'b0, want.read_data}, {1'b0, got.read_data});
                end
                if (got.irq_out !== want.irq_out)
                begin
                    log_mismatch("irq_out", {32'd0, want.irq_out}, {32'd0, got.irq_out});
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        lic_item_t   acc;
        lic_result_t typed_res;
        logic [7:0]  rev;
        int unsigned pick;
        logic [31:0] sparse;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_table[i])
        begin
            acc.op          = dir_table[i].op;
            acc.reg_offset  = dir_table[i].off;
            acc.write_data  = dir_table[i].data;
            acc.line_levels = dir_table[i].levels;
            typed_res.read_data = dir_table[i].rd;
            typed_res.irq_out   = dir_table[i].irq;
            send_access(acc, dir_table[i].typed, typed_res);
        end

        // random phases, each with a revision and gap pattern set at its start
        for (int ph = 0; ph < PHASES; ph++)
        begin
            s_axis_tvalid <= 1'b0;
            while (awaited_replies.size() != 0)
            begin
                @(negedge clk);
            end
            rev = (ph == 5) ? 8'($urandom_range(255)) : phase_rev[ph];
            cfg_we    <= 1'b1;
            cfg_wdata <= rev;
            rev_value = rev;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    acc.op = OP_TICK;
                end
                else if (pick < 58)
                begin
                    acc.op = OP_READ;
                end
                else if (pick < 95)
                begin
                    acc.op = OP_WRITE;
                end
                else
                begin
                    acc.op = OP_NONE;
                end
                pick = $urandom_range(7);
                acc.reg_offset = (pick < 6) ? known_offs[pick] : 8'($urandom_range(255));
                sparse = $urandom() & $urandom() & $urandom();
                acc.write_data = $urandom();
                // acks half the time aimed at bits that are pending, masks often sparse
                if (acc.reg_offset == OFF_ACK && $urandom_range(1))
                begin
                    acc.write_data = pend_word & $urandom();
                end
                else if (acc.reg_offset == OFF_MASK && $urandom_range(1))
                begin
                    acc.write_data = sparse;
                end
                // mostly few active lines so pending does not saturate
                acc.line_levels = ($urandom_range(3) == 0) ? $urandom() : (pol_word ^ sparse);
                send_access(acc, 1'b0, typed_res);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
